// ===== rtl/phrm_pkg.sv =====
// Shared definitions for the partial horizontal row mirror.
// Holds register codes, widths, reset values and the structs that pass between modules.
// No dependencies.
package phrm_pkg;

    // Widths fixed by the register and field definitions.
    localparam int BYTE_W          = 8;
    localparam int ROW_WIDTH_W     = 11;
    localparam int IMAGE_HEIGHT_W  = 13;
    localparam int CHANNEL_COUNT_W = 3;
    localparam int MIRROR_LIMIT_W  = 12;
    localparam int CFG_DATA_W      = 13;
    localparam int CFG_ADDR_W      = 2;

    // Defaults for the top-level size parameters.
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_MAX_HEIGHT   = 4096;

    // Register reset values.
    localparam logic [ROW_WIDTH_W-1:0]     RST_ROW_WIDTH     = 11'd1024;
    localparam logic [IMAGE_HEIGHT_W-1:0]  RST_IMAGE_HEIGHT  = 13'd1024;
    localparam logic [CHANNEL_COUNT_W-1:0] RST_CHANNEL_COUNT = 3'd3;
    localparam logic [MIRROR_LIMIT_W-1:0]  RST_MIRROR_LIMIT  = 12'd0;

    // Output queue geometry.
    localparam int OFIFO_PTR_W = 2;
    localparam int OFIFO_DEPTH = 1 << OFIFO_PTR_W;
    localparam int OFIFO_CNT_W = OFIFO_PTR_W + 1;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ROW_WIDTH     = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2,
        CFG_MIRROR_LIMIT  = 2'd3
    } cfg_index_t;

    // Input kinds carried in tuser.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic [ROW_WIDTH_W-1:0]     row_width;
        logic [IMAGE_HEIGHT_W-1:0]  image_height;
        logic [CHANNEL_COUNT_W-1:0] channel_count;
        logic [MIRROR_LIMIT_W-1:0]  mirror_row_limit;
    } cfg_t;

    // Sideband of a row store read that yields one result.
    typedef struct packed {
        logic valid;
        logic row_end;
        logic frame_end;
    } rd_req_t;

    // One result as it waits in the output queue.
    typedef struct packed {
        logic              frame_end;
        logic              row_end;
        logic [BYTE_W-1:0] data;
    } out_item_t;

endpackage

// ===== rtl/phrm_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module phrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read in the same cycle; a read of the written address returns the old data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/phrm_ctrl.sv =====
// Row store controller: write and read positions, bank selection and address generation.
// Depends on phrm_pkg.
module phrm_ctrl #(
    parameter int MAX_WIDTH    = phrm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = phrm_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_HEIGHT   = phrm_pkg::DEF_MAX_HEIGHT,
    localparam int BANK = MAX_WIDTH * MAX_CHANNELS,
    localparam int AW   = $clog2(2 * BANK)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  phrm_pkg::cfg_t              cfg,
    input  logic                        accept,
    input  logic                        cmd,
    input  logic [phrm_pkg::BYTE_W-1:0] pixel_byte,
    output logic                        ram_wr_en,
    output logic [AW-1:0]               ram_wr_addr,
    output logic [phrm_pkg::BYTE_W-1:0] ram_wr_data,
    output logic                        ram_rd_en,
    output logic [AW-1:0]               ram_rd_addr,
    output phrm_pkg::rd_req_t           rd_req
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int PW  = $clog2(MAX_WIDTH);
    localparam int CHW = $clog2(MAX_CHANNELS + 1);
    localparam int CIW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RIW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int BW  = $clog2(BANK);
    localparam int RBW = $clog2(BANK + 1);
    localparam int WXW = (WW > phrm_pkg::ROW_WIDTH_W) ? WW : phrm_pkg::ROW_WIDTH_W;
    localparam int CXW = (CHW > phrm_pkg::CHANNEL_COUNT_W) ? CHW : phrm_pkg::CHANNEL_COUNT_W;
    localparam int HXW = (HW > phrm_pkg::IMAGE_HEIGHT_W) ? HW : phrm_pkg::IMAGE_HEIGHT_W;
    localparam int LXW = (RIW > phrm_pkg::MIRROR_LIMIT_W) ? RIW : phrm_pkg::MIRROR_LIMIT_W;

    // Position state.
    logic           write_bank_reg, write_bank_next;
    logic [BW-1:0]  write_position_reg, write_position_next;
    logic [RIW-1:0] write_row_reg, write_row_next;
    logic [PW-1:0]  read_pixel_reg, read_pixel_next;
    logic [CIW-1:0] read_channel_reg, read_channel_next;
    logic [RIW-1:0] read_row_reg, read_row_next;
    logic           row_ready_reg, row_ready_next;

    // Effective row shape after clamping the registers.
    logic [WXW-1:0] rw_x;
    logic [CXW-1:0] cc_x;
    logic [HXW-1:0] ih_x;
    logic [WW-1:0]  w_eff;
    logic [CHW-1:0] ch_eff;
    logic [HW-1:0]  h_eff;
    logic [PW-1:0]  p_max;
    logic [CIW-1:0] c_max;
    logic [RIW-1:0] h_max;
    logic [RBW-1:0] row_bytes;
    logic [BW-1:0]  pos_max;

    // Read side terms.
    logic [PW-1:0]  p;
    logic [CIW-1:0] c;
    logic [PW-1:0]  src;
    logic           mirror;
    logic           rd_last;
    logic           rd_fend;

    // Write side terms.
    logic [BW-1:0]  pos;
    logic           wr_row_done;
    logic           do_read;
    logic           do_write;

    // Clamp the row shape: zero acts as one, larger values saturate at the maxima.
    always_comb begin
        rw_x = WXW'(cfg.row_width);
        cc_x = CXW'(cfg.channel_count);
        ih_x = HXW'(cfg.image_height);
        if (rw_x == '0) begin
            w_eff = WW'(1);
        end else if (rw_x > WXW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(rw_x);
        end
        if (cc_x == '0) begin
            ch_eff = CHW'(1);
        end else if (cc_x > CXW'(MAX_CHANNELS)) begin
            ch_eff = CHW'(MAX_CHANNELS);
        end else begin
            ch_eff = CHW'(cc_x);
        end
        if (ih_x == '0) begin
            h_eff = HW'(1);
        end else if (ih_x > HXW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(ih_x);
        end
    end

    assign p_max     = PW'(w_eff - WW'(1));
    assign c_max     = CIW'(ch_eff - CHW'(1));
    assign h_max     = RIW'(h_eff - HW'(1));
    assign row_bytes = RBW'(w_eff) * RBW'(ch_eff);
    assign pos_max   = BW'(row_bytes - RBW'(1));

    // Read address: mirrored rows take the pixel from the far end of the row.
    always_comb begin
        p       = (read_pixel_reg < p_max) ? read_pixel_reg : p_max;
        c       = (read_channel_reg < c_max) ? read_channel_reg : c_max;
        mirror  = LXW'(read_row_reg) <= LXW'(cfg.mirror_row_limit);
        src     = mirror ? (p_max - p) : p;
        rd_last = (p == p_max) && (c == c_max);
        rd_fend = rd_last && (read_row_reg >= h_max);
    end

    assign ram_rd_addr = AW'(src) * AW'(ch_eff) + AW'(c)
                       + (write_bank_reg ? '0 : AW'(BANK));

    // Write address within the current bank.
    assign pos         = (write_position_reg < pos_max) ? write_position_reg : pos_max;
    assign wr_row_done = (pos == pos_max);
    assign ram_wr_addr = AW'(pos) + (write_bank_reg ? AW'(BANK) : '0);
    assign ram_wr_data = pixel_byte;

    assign do_read   = accept && row_ready_reg;
    assign do_write  = accept && (cmd == phrm_pkg::CMD_PIXEL);
    assign ram_rd_en = do_read;
    assign ram_wr_en = do_write;

    assign rd_req.valid     = do_read;
    assign rd_req.row_end   = rd_last;
    assign rd_req.frame_end = rd_fend;

    // Next-state logic; a finished write row overrides the read position update.
    always_comb begin
        write_bank_next     = write_bank_reg;
        write_position_next = write_position_reg;
        write_row_next      = write_row_reg;
        read_pixel_next     = read_pixel_reg;
        read_channel_next   = read_channel_reg;
        read_row_next       = read_row_reg;
        row_ready_next      = row_ready_reg;

        if (do_read) begin
            if (rd_last) begin
                row_ready_next    = 1'b0;
                read_pixel_next   = '0;
                read_channel_next = '0;
            end else if (c == c_max) begin
                read_channel_next = '0;
                read_pixel_next   = p + PW'(1);
            end else begin
                read_channel_next = c + CIW'(1);
                read_pixel_next   = p;
            end
        end

        if (do_write) begin
            if (wr_row_done) begin
                write_bank_next     = ~write_bank_reg;
                row_ready_next      = 1'b1;
                read_pixel_next     = '0;
                read_channel_next   = '0;
                read_row_next       = write_row_reg;
                write_position_next = '0;
                write_row_next      = (write_row_reg >= h_max) ? '0 : write_row_reg + RIW'(1);
            end else begin
                write_position_next = pos + BW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_bank_reg     <= 1'b0;
            write_position_reg <= '0;
            write_row_reg      <= '0;
            read_pixel_reg     <= '0;
            read_channel_reg   <= '0;
            read_row_reg       <= '0;
            row_ready_reg      <= 1'b0;
        end else begin
            write_bank_reg     <= write_bank_next;
            write_position_reg <= write_position_next;
            write_row_reg      <= write_row_next;
            read_pixel_reg     <= read_pixel_next;
            read_channel_reg   <= read_channel_next;
            read_row_reg       <= read_row_next;
            row_ready_reg      <= row_ready_next;
        end
    end

endmodule

// ===== rtl/phrm_ofifo.sv =====
// Small output queue that decouples the row store read from the result channel.
// Depends on phrm_pkg.
module phrm_ofifo (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             push,
    input  phrm_pkg::out_item_t              push_item,
    input  logic                             pop,
    output phrm_pkg::out_item_t              head,
    output logic [phrm_pkg::OFIFO_CNT_W-1:0] count
);

    phrm_pkg::out_item_t                entry_reg [phrm_pkg::OFIFO_DEPTH];
    logic [phrm_pkg::OFIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [phrm_pkg::OFIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [phrm_pkg::OFIFO_CNT_W-1:0]   count_reg, count_next;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + phrm_pkg::OFIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + phrm_pkg::OFIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + phrm_pkg::OFIFO_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - phrm_pkg::OFIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ===== rtl/partial_horizontal_row_mirror.sv =====
// Results pass the registered row store read, then the output queue; rows come out one row late.
// Throughput: one request per cycle, set by the row store's single write and single read port,
// while the output queue has room; it keeps requests flowing while a result waits to be taken.
// Reset: synchronous, active low; clears positions, bank, queue and registers to defaults.
// The row store itself is not cleared and holds undefined bytes until written.
// Depends on phrm_pkg, phrm_ram, phrm_ctrl and phrm_ofifo.
module partial_horizontal_row_mirror #(
    parameter int MAX_WIDTH    = phrm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = phrm_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_HEIGHT   = phrm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [phrm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [phrm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] pixel_byte
    input  logic                            s_tuser,  // [0] cmd
    // Result channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,  // [7:0] out_byte
    output logic                            m_tlast,  // row_end
    output logic                            m_tuser   // [0] frame_end
);

    localparam int BANK   = MAX_WIDTH * MAX_CHANNELS;
    localparam int DEPTH  = 2 * BANK;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = phrm_pkg::OFIFO_CNT_W;
    localparam int QDEPTH = phrm_pkg::OFIFO_DEPTH;

    phrm_pkg::cfg_t      cfg_reg, cfg_next;
    phrm_pkg::rd_req_t   rd_req;
    phrm_pkg::rd_req_t   s1_reg, s1_next;
    phrm_pkg::out_item_t push_item;
    phrm_pkg::out_item_t head;

    logic                          accept;
    logic                          ram_wr_en;
    logic [AW-1:0]                 ram_wr_addr;
    logic [phrm_pkg::BYTE_W-1:0]   ram_wr_data;
    logic                          ram_rd_en;
    logic [AW-1:0]                 ram_rd_addr;
    logic [phrm_pkg::BYTE_W-1:0]   ram_rd_data;
    logic [CNT_W-1:0]              fifo_count;
    logic                          pop;

    // Configuration registers.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (phrm_pkg::cfg_index_t'(cfg_addr))
                phrm_pkg::CFG_ROW_WIDTH: begin
                    cfg_next.row_width = cfg_wdata[phrm_pkg::ROW_WIDTH_W-1:0];
                end
                phrm_pkg::CFG_IMAGE_HEIGHT: begin
                    cfg_next.image_height = cfg_wdata[phrm_pkg::IMAGE_HEIGHT_W-1:0];
                end
                phrm_pkg::CFG_CHANNEL_COUNT: begin
                    cfg_next.channel_count = cfg_wdata[phrm_pkg::CHANNEL_COUNT_W-1:0];
                end
                phrm_pkg::CFG_MIRROR_LIMIT: begin
                    cfg_next.mirror_row_limit = cfg_wdata[phrm_pkg::MIRROR_LIMIT_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_width        <= phrm_pkg::RST_ROW_WIDTH;
            cfg_reg.image_height     <= phrm_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.channel_count    <= phrm_pkg::RST_CHANNEL_COUNT;
            cfg_reg.mirror_row_limit <= phrm_pkg::RST_MIRROR_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Take a request only when the queue has room for it and the read in flight.
    assign s_tready = ({1'b0, fifo_count} + (CNT_W + 1)'(s1_reg.valid))
                      <= (CNT_W + 1)'(QDEPTH - 2);
    assign accept   = s_tvalid && s_tready;

    phrm_ctrl #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .accept      (accept),
        .cmd         (s_tuser),
        .pixel_byte  (s_tdata),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .rd_req      (rd_req)
    );

    phrm_ram #(
        .WIDTH (phrm_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_row_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The sideband is registered once, so it lines up with the registered row store read data.
    assign s1_next = rd_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
        end else begin
            s1_reg <= s1_next;
        end
    end

    assign push_item.frame_end = s1_reg.frame_end;
    assign push_item.row_end   = s1_reg.row_end;
    assign push_item.data      = ram_rd_data;

    assign m_tvalid = (fifo_count != '0);
    assign pop      = m_tvalid && m_tready;

    phrm_ofifo u_ofifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_reg.valid),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .count     (fifo_count)
    );

    assign m_tdata = head.data;
    assign m_tlast = head.row_end;
    assign m_tuser = head.frame_end;

`ifndef NO_ASSERTIONS
    // A read result never arrives at a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_reg.valid |-> (fifo_count < CNT_W'(QDEPTH)))
        else $error("output queue overflow");

    // Every read result stems from a request taken in the previous cycle.
    a_read_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_reg.valid |-> $past(s_tvalid && s_tready))
        else $error("read result without a request");

    // The end of a frame is always the end of a row.
    a_frame_ends_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end without row end");

    // An empty queue with nothing in flight is always ready for a request.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ((fifo_count == '0) && !s1_reg.valid) |-> s_tready)
        else $error("stalled while empty");
`endif

endmodule
